// File: sv/sbps_pkg.sv
package sbps_pkg;

  // Payload of one input item.
  typedef struct packed {
    logic [31:0] module_clock;
    logic [31:0] target_baud;
  } in_item_t;

  // Payload of one result item.
  typedef struct packed {
    logic        double_rate_index;
    logic [1:0]  prescaler_index;
    logic [3:0]  scaler_index;
    logic [17:0] achieved_divisor;
    logic        zero_baud_error;
  } out_item_t;

  localparam int unsigned QuotW   = 32;
  localparam int unsigned DivW    = 18;
  localparam int unsigned CandW   = 7;
  localparam int unsigned NumCand = 128;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [QuotW-1:0] num;
    logic [QuotW-1:0] rem;
    logic [QuotW-1:0] quot;
    logic [QuotW-1:0] baud;
  } div_data_t;

  // Data handed from one search cell to the next.
  typedef struct packed {
    logic [QuotW-1:0] quot;
    logic             have;
    logic [QuotW-1:0] gap;
    logic [CandW-1:0] idx;
    logic [DivW-1:0]  divisor;
    logic             err;
  } srch_data_t;

  // Effective divisor of a candidate: index bits are {dbr, pbr, br}.
  function automatic logic [DivW-1:0] cand_div(input logic [CandW-1:0] k);
    logic [2:0]  pre;
    logic [15:0] scl;
    logic [15:0] scl_eff;
    begin
      case (k[5:4])
        2'd0:    pre = 3'd2;
        2'd1:    pre = 3'd3;
        2'd2:    pre = 3'd5;
        default: pre = 3'd7;
      endcase
      case (k[3:0])
        4'd0:    scl = 16'd2;
        4'd1:    scl = 16'd4;
        4'd2:    scl = 16'd6;
        default: scl = 16'd1 << k[3:0];
      endcase
      scl_eff = k[6] ? (scl >> 1) : scl;
      cand_div = DivW'(scl_eff) * DivW'(pre);
    end
  endfunction

endpackage

// File: sv/spi_baud_prescaler_search_core.sv
// Baud prescaler search: every item (module clock, target baud) passes through a
// chain of 32 divider cells, one quotient bit per cell, then a chain of 128 search
// cells, one per (double-rate, prescaler, scaler) combination, each keeping the
// closest divisor so far. One item is taken per cycle; the whole chain advances
// together, so it holds while a finished result is stalled.
// A zero target baud gives zero_baud_error with all other fields zero.
module spi_baud_prescaler_search_core import sbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       adv;
  logic       dv [QuotW+1];
  div_data_t  dd [QuotW+1];
  logic       sv [NumCand+1];
  srch_data_t sd [NumCand+1];

  // The chain moves when its last stage is empty or being taken.
  assign adv        = !sv[NumCand] || !out_stall_i;
  assign in_stall_o = !adv;

  assign dv[0]      = in_valid_i;
  assign dd[0].num  = in_item_i.module_clock;
  assign dd[0].rem  = '0;
  assign dd[0].quot = '0;
  assign dd[0].baud = in_item_i.target_baud;

  for (genvar i = 0; i < QuotW; i++) begin : g_div
    sbps_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(dv[i]),
      .data_i (dd[i]),
      .valid_o(dv[i+1]),
      .data_o (dd[i+1])
    );
  end

  // Seed the search with the quotient and no best yet.
  assign sv[0]         = dv[QuotW];
  assign sd[0].quot    = dd[QuotW].quot;
  assign sd[0].have    = 1'b0;
  assign sd[0].gap     = '0;
  assign sd[0].idx     = '0;
  assign sd[0].divisor = '0;
  assign sd[0].err     = (dd[QuotW].baud == '0);

  for (genvar k = 0; k < NumCand; k++) begin : g_srch
    sbps_srch_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .idx_i  (CandW'(k)),
      .valid_i(sv[k]),
      .data_i (sd[k]),
      .valid_o(sv[k+1]),
      .data_o (sd[k+1])
    );
  end

  // Result fields; an error item reports zeros.
  always_comb begin
    out_item_o = '0;
    if (sd[NumCand].err) begin
      out_item_o.zero_baud_error = 1'b1;
    end else begin
      out_item_o.double_rate_index = sd[NumCand].idx[6];
      out_item_o.prescaler_index   = sd[NumCand].idx[5:4];
      out_item_o.scaler_index      = sd[NumCand].idx[3:0];
      out_item_o.achieved_divisor  = sd[NumCand].divisor;
    end
  end

  assign out_valid_o = sv[NumCand];

endmodule

// File: sv/sbps_div_cell.sv
module sbps_div_cell import sbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_data_t data_i,
  output logic      valid_o,
  output div_data_t data_o
);

  logic        valid_q;
  div_data_t   data_q, data_d;
  logic [32:0] rem_sh;
  logic        ge;

  // One restoring division step: bring down the next dividend bit.
  always_comb begin
    rem_sh      = {data_i.rem, data_i.num[31]};
    ge          = rem_sh >= {1'b0, data_i.baud};
    data_d      = data_i;
    data_d.num  = {data_i.num[30:0], 1'b0};
    data_d.rem  = ge ? 32'(rem_sh - {1'b0, data_i.baud}) : rem_sh[31:0];
    data_d.quot = {data_i.quot[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/sbps_srch_cell.sv
module sbps_srch_cell import sbps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [CandW-1:0] idx_i,
  input  logic             valid_i,
  input  srch_data_t       data_i,
  output logic             valid_o,
  output srch_data_t       data_o
);

  logic             valid_q;
  srch_data_t       data_q, data_d;
  logic [DivW-1:0]  cand;
  logic [QuotW-1:0] cand_w;
  logic [QuotW-1:0] gap;

  // Compare this cell's candidate against the best so far; strictly closer wins.
  always_comb begin
    cand   = cand_div(idx_i);
    cand_w = QuotW'(cand);
    gap    = (data_i.quot >= cand_w) ? (data_i.quot - cand_w) : (cand_w - data_i.quot);
    data_d = data_i;
    if (!data_i.have || (gap < data_i.gap)) begin
      data_d.have    = 1'b1;
      data_d.gap     = gap;
      data_d.idx     = idx_i;
      data_d.divisor = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
